// File: rtl/core/cfz_pkg.sv
// cfz_pkg: shared types and constants of the candle flicker zone engine.
// Used by cfz_noise and candle_flicker_zone_engine; no dependencies.
package cfz_pkg;

  localparam int MAX_ZONES_DEF = 16;
  localparam int ZONE_LEDS_DEF = 8;
  localparam int OUT_CAP       = 8;

  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 17;

  localparam logic [14:0] RESET_LEVEL = 15'd12800;

  localparam logic [31:0] HASH_MUL  = 32'd60493;
  localparam logic [31:0] HASH_ADD1 = 32'd19990303;
  localparam logic [31:0] HASH_ADD2 = 32'd1376312589;
  localparam logic [31:0] NOISE_HALF = 32'h4000_0000;
  localparam logic [16:0] DIP_FLOOR  = 17'd19661;
  localparam logic [28:0] RECIP_1000 = 29'd274877907;
  localparam logic [6:0]  ZONE_SEED  = 7'd100;
  localparam logic [12:0] RECIP_100  = 13'd5243;

  typedef enum logic [2:0] {
    CFG_BASE  = 3'd0,
    CFG_MIN   = 3'd1,
    CFG_MAX   = 3'd2,
    CFG_AMP   = 3'd3,
    CFG_SPEED = 3'd4,
    CFG_DIP   = 3'd5,
    CFG_REC   = 3'd6,
    CFG_COLOR = 3'd7
  } cfg_idx_e;

  typedef enum logic [3:0] {
    S_IDLE,
    S_TIME,
    S_N1GO,
    S_N1WAIT,
    S_TGT,
    S_TGT2,
    S_DIV,
    S_N2GO,
    S_N2WAIT,
    S_DIP,
    S_EASE,
    S_UPD,
    S_VAL1,
    S_VAL2,
    S_EMIT
  } state_e;

endpackage

// File: rtl/core/candle_flicker_zone_engine.sv
// candle_flicker_zone_engine: per-zone candle flicker with HSV LED output.
// Top level; depends on cfz_pkg and cfz_noise.
//
// One request updates one zone and then emits up to min(ZONE_LEDS, 8) LEDs, one per cycle
// that the output is not stalled. A dip adds a reciprocal multiply for time/1000 and a
// second hash. Each hash holds the sequencer while the noise unit runs.
// Zone levels sit in a one-port synchronous RAM with per-entry valid bits, so no clearing pass
// follows reset. One request is processed at a time, and no new one is accepted until the
// current one is done; zones at or above MAX_ZONES only advance time on a new frame and
// emit nothing.
module candle_flicker_zone_engine #(
  parameter int MAX_ZONES = cfz_pkg::MAX_ZONES_DEF,
  parameter int ZONE_LEDS = cfz_pkg::ZONE_LEDS_DEF
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           cfg_we_i,
  input  logic [cfz_pkg::CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [cfz_pkg::CFG_DATA_W-1:0] cfg_data_i,
  input  logic                           in_valid_i,
  output logic                           in_stall_o,
  input  logic                           new_frame_i,
  input  logic [15:0]                    delta_ms_i,
  input  logic [3:0]                     zone_i,
  input  logic [15:0]                    dip_draw_i,
  input  logic [7:0]                     pixel_limit_i,
  output logic                           out_valid_o,
  input  logic                           out_stall_i,
  output logic [6:0]                     led_index_o,
  output logic [7:0]                     hue_o,
  output logic [7:0]                     saturation_o,
  output logic [7:0]                     value_o,
  output logic                           last_o
);
  import cfz_pkg::*;

  localparam int ZW = (MAX_ZONES > 1) ? $clog2(MAX_ZONES) : 1;
  localparam int IW = $clog2(16 * ZONE_LEDS + 256);
  localparam int NE = (ZONE_LEDS < OUT_CAP) ? ZONE_LEDS : OUT_CAP;
  localparam logic [2:0]    LAST_I = 3'(NE - 1);
  localparam logic [IW-1:0] LPZ_W  = IW'(ZONE_LEDS);
  localparam logic [6:0]    NZ_W   = 7'(MAX_ZONES);

  // configuration
  logic [14:0] base_q, min_q, max_q;
  logic [15:0] amp_q, speed_q, color_q;
  logic [16:0] dipp_q, rate_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      base_q  <= 15'd12800;
      min_q   <= 15'd5120;
      max_q   <= 15'd25600;
      amp_q   <= 16'd10240;
      speed_q <= 16'd256;
      dipp_q  <= 17'd3277;
      rate_q  <= 17'd6554;
      color_q <= 16'd5375;
    end else if (cfg_we_i) begin
      case (cfg_idx_e'(cfg_idx_i))
        CFG_BASE:  base_q  <= cfg_data_i[14:0];
        CFG_MIN:   min_q   <= cfg_data_i[14:0];
        CFG_MAX:   max_q   <= cfg_data_i[14:0];
        CFG_AMP:   amp_q   <= cfg_data_i[15:0];
        CFG_SPEED: speed_q <= cfg_data_i[15:0];
        CFG_DIP:   dipp_q  <= cfg_data_i;
        CFG_REC:   rate_q  <= cfg_data_i;
        CFG_COLOR: color_q <= cfg_data_i[15:0];
        default:   ;
      endcase
    end
  end

  state_e state_q, state_d;

  logic               nf_q;
  logic [15:0]        delta_q, draw_q;
  logic [3:0]         zone_q;
  logic [7:0]         pix_q;
  logic [31:0]        time_q, num_q;
  logic [14:0]        level_q;
  logic signed [17:0] tp_q;
  logic signed [18:0] tgt_q;
  logic signed [21:0] ep_q;
  logic [14:0]        vp_q;
  logic [7:0]         val_q;
  logic [IW-1:0]      idx_q;
  logic [2:0]         cnt_q;
  logic [MAX_ZONES-1:0] vld_q;

  // zone level memory
  logic [14:0] mem [MAX_ZONES];
  logic [14:0] rd_q;
  logic        mem_we;
  logic [14:0] new_level;
  logic [6:0]  zone_x;
  logic [ZW-1:0] addr;

  assign zone_x = 7'(zone_q);
  assign addr   = zone_x[ZW-1:0];

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem[addr] <= new_level;
    end
    rd_q <= mem[addr];
  end

  // noise unit
  logic        nz_start, nz_done;
  logic [31:0] nz_a, nz_b;
  logic [30:0] nz_n;

  assign nz_a = (state_q == S_N2GO) ? num_q : time_q;
  assign nz_b = (state_q == S_N2GO) ? 32'(zone_q) : 32'(zone_q) * 32'(ZONE_SEED);

  cfz_noise u_noise (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (nz_start),
    .a_i     (nz_a),
    .b_i     (nz_b),
    .done_o  (nz_done),
    .noise_o (nz_n)
  );

  // datapath
  logic [31:0]        tprod;
  logic signed [31:0] nc;
  logic signed [48:0] aprod;
  logic [16:0]        sev;
  logic [31:0]        dprod;
  logic [60:0]        dq;
  logic signed [19:0] diff;
  logic signed [37:0] eprod;
  logic signed [21:0] nl;
  logic [22:0]        vprod;
  logic [27:0]        qprod;
  logic [8:0]         q100;
  logic               zone_ok, dip_hit, none_left, is_last;
  logic [IW-1:0]      idx_nx;

  assign tprod = delta_q * speed_q;
  assign nc    = $signed({1'b0, nz_n}) - $signed(NOISE_HALF);
  assign aprod = $signed({1'b0, amp_q}) * nc;
  assign sev   = DIP_FLOOR + {2'b00, nz_n[30:16]};
  assign dprod = level_q * sev;
  // time / 1000 by reciprocal, exact over 32 bits
  assign dq    = time_q * RECIP_1000;
  assign diff  = $signed({tgt_q[18], tgt_q}) - $signed({5'b00000, level_q});
  assign eprod = diff * $signed({1'b0, rate_q});
  assign nl    = $signed({7'b0000000, level_q}) + ep_q;
  assign vprod = level_q * 8'd255;
  assign qprod = vp_q * RECIP_100;
  assign q100  = qprod[27:19];

  always_comb begin
    if (nl > $signed({7'b0000000, max_q})) begin
      new_level = max_q;
    end else begin
      new_level = nl[14:0];
    end
    if (nl < $signed({7'b0000000, min_q}) || max_q < min_q) begin
      if (nl > $signed({7'b0000000, max_q})) begin
        new_level = (max_q < min_q) ? min_q : max_q;
      end else begin
        new_level = min_q;
      end
    end
  end

  assign zone_ok   = zone_x < NZ_W;
  assign dip_hit   = {1'b0, draw_q} < dipp_q;
  assign idx_nx    = idx_q + IW'(1);
  assign none_left = idx_q >= IW'(pix_q);
  assign is_last   = (cnt_q == LAST_I) || (idx_nx >= IW'(pix_q));

  // next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      S_IDLE:   if (in_valid_i) state_d = S_TIME;
      S_TIME:   state_d = zone_ok ? S_N1GO : S_IDLE;
      S_N1GO:   state_d = S_N1WAIT;
      S_N1WAIT: if (nz_done) state_d = S_TGT;
      S_TGT:    state_d = S_TGT2;
      S_TGT2:   state_d = dip_hit ? S_DIV : S_EASE;
      S_DIV:    state_d = S_N2GO;
      S_N2GO:   state_d = S_N2WAIT;
      S_N2WAIT: if (nz_done) state_d = S_DIP;
      S_DIP:    state_d = S_EASE;
      S_EASE:   state_d = S_UPD;
      S_UPD:    state_d = S_VAL1;
      S_VAL1:   state_d = S_VAL2;
      S_VAL2:   state_d = none_left ? S_IDLE : S_EMIT;
      S_EMIT:   if (!out_stall_i && is_last) state_d = S_IDLE;
      default:  state_d = S_IDLE;
    endcase
  end

  // control outputs
  always_comb begin
    in_stall_o  = (state_q != S_IDLE);
    out_valid_o = (state_q == S_EMIT);
    nz_start    = (state_q == S_N1GO) || (state_q == S_N2GO);
    mem_we      = (state_q == S_UPD);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      time_q  <= '0;
      vld_q   <= '0;
    end else begin
      state_q <= state_d;
      if (state_q == S_TIME && nf_q) begin
        time_q <= time_q + {8'h00, tprod[31:8]};
      end
      if (state_q == S_UPD) begin
        vld_q[addr] <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    case (state_q)
      S_IDLE: begin
        nf_q    <= new_frame_i;
        delta_q <= delta_ms_i;
        zone_q  <= zone_i;
        draw_q  <= dip_draw_i;
        pix_q   <= pixel_limit_i;
        idx_q   <= IW'(zone_i) * LPZ_W;
        cnt_q   <= 3'd0;
      end
      S_N1GO: level_q <= vld_q[addr] ? rd_q : RESET_LEVEL;
      S_TGT:  tp_q <= aprod[48:31];
      S_TGT2: begin
        tgt_q <= $signed({4'b0000, base_q}) + $signed({tp_q[17], tp_q});
      end
      S_DIV:  num_q <= {9'd0, dq[60:38]};
      S_DIP:  level_q <= dprod[30:16];
      S_EASE: ep_q <= eprod[37:16];
      S_UPD:  level_q <= new_level;
      S_VAL1: vp_q <= vprod[22:8];
      S_VAL2: val_q <= (q100 > 9'd255) ? 8'd255 : q100[7:0];
      S_EMIT: begin
        if (!out_stall_i) begin
          idx_q <= idx_nx;
          cnt_q <= cnt_q + 3'd1;
        end
      end
      default: ;
    endcase
  end

  assign led_index_o  = idx_q[6:0];
  assign hue_o        = color_q[15:8];
  assign saturation_o = color_q[7:0];
  assign value_o      = val_q;
  assign last_o       = is_last;

endmodule

// File: rtl/core/cfz_noise.sv
// cfz_noise: multi-cycle 31-bit hash noise of two 32-bit words.
// Three 32x32 multiplies, one per phase, run for each word in turn; depends on cfz_pkg.
module cfz_noise (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start_i,
  input  logic [31:0] a_i,
  input  logic [31:0] b_i,
  output logic        done_o,
  output logic [30:0] noise_o
);
  import cfz_pkg::*;

  logic        busy_q, opb_q, done_q;
  logic [1:0]  ph_q;
  logic [31:0] a_q, b_q, v_q, p_q;
  logic [30:0] sum_q;
  logic [31:0] x_sel, vx, sq, p2, h;

  assign x_sel = opb_q ? b_q : a_q;
  assign vx    = x_sel ^ (x_sel >> 13);
  assign sq    = vx * vx;
  assign p2    = p_q * HASH_MUL + HASH_ADD1;
  assign h     = v_q * p_q + HASH_ADD2;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      opb_q  <= 1'b0;
      done_q <= 1'b0;
      ph_q   <= 2'd0;
      a_q    <= '0;
      b_q    <= '0;
      v_q    <= '0;
      p_q    <= '0;
      sum_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        opb_q  <= 1'b0;
        ph_q   <= 2'd0;
        a_q    <= a_i;
        b_q    <= b_i;
        sum_q  <= '0;
      end else if (busy_q) begin
        case (ph_q)
          2'd0: begin
            v_q  <= vx;
            p_q  <= sq;
            ph_q <= 2'd1;
          end
          2'd1: begin
            p_q  <= p2;
            ph_q <= 2'd2;
          end
          default: begin
            sum_q <= sum_q + h[30:0];
            ph_q  <= 2'd0;
            if (opb_q) begin
              busy_q <= 1'b0;
              done_q <= 1'b1;
            end else begin
              opb_q <= 1'b1;
            end
          end
        endcase
      end
    end
  end

  assign done_o  = done_q;
  assign noise_o = sum_q;

endmodule
